>>> rtl/btt_pkg.sv
`timescale 1ns / 1ps

package btt_pkg;

   // raw byte codes
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   // whitespace modes
   localparam logic [1:0] SM_NORMAL = 2'd0;
   localparam logic [1:0] SM_SKIP   = 2'd1;
   localparam logic [1:0] SM_VALUE  = 2'd2;

   // parser states
   localparam logic [2:0] PS_NAME   = 3'd0;
   localparam logic [2:0] PS_IDENT  = 3'd1;
   localparam logic [2:0] PS_CLOSEQ = 3'd2;
   localparam logic [2:0] PS_PROP   = 3'd3;
   localparam logic [2:0] PS_VAL1   = 3'd4;
   localparam logic [2:0] PS_VALN   = 3'd5;

   // character classes
   localparam logic [2:0] CLS_NAME  = 3'd0;
   localparam logic [2:0] CLS_IDENT = 3'd1;
   localparam logic [2:0] CLS_PROP  = 3'd2;
   localparam logic [2:0] CLS_VALUE = 3'd3;
   localparam logic [2:0] CLS_DELIM = 3'd4;

   // status codes
   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_SYNTAX     = 2'd1;
   localparam logic [1:0] ERR_INCOMPLETE = 2'd2;

   typedef struct packed {
      logic [1:0]  space_mode;
      logic [2:0]  parse_state;
      logic        token_nonempty;
      logic [15:0] element_total;
      logic [1:0]  error_code;
   } ps_type;

   typedef struct packed {
      ps_type     st;
      logic       emit;
      logic [2:0] cls;
   } feed_type;

   // one queued step: up to two result words plus the shared status
   typedef struct packed {
      logic        two;
      logic        has0;
      logic [7:0]  ch0;
      logic [2:0]  cl0;
      logic [7:0]  ch1;
      logic [2:0]  cl1;
      logic [1:0]  status;
      logic [15:0] total;
      logic        eot;
   } rec_type;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_delim(logic [7:0] c);
      return (c == CH_LBRACE) || (c == CH_QUOTE) || (c == CH_COLON) ||
             (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_RBRACE);
   endfunction

   // whitespace filter followed by the syntax checker, for one character
   function automatic feed_type feed_char(ps_type s, logic [7:0] c);
      feed_type   r;
      logic [1:0] m;
      logic       keep;
      logic       d;
      r      = '{st: s, emit: 1'b0, cls: CLS_NAME};
      m      = ((s.space_mode == SM_SKIP) || (s.space_mode == SM_VALUE)) ?
               s.space_mode : SM_NORMAL;
      keep   = 1'b1;
      d      = is_delim(c);
      if (c == CH_LF) begin
         r.st.space_mode = SM_NORMAL;
         keep            = 1'b0;
      end else begin
         if (m == SM_NORMAL) begin
            if (is_blank(c)) keep = 1'b0;
            else if (c == CH_COLON) m = SM_SKIP;
         end else if (m == SM_SKIP) begin
            if (is_blank(c)) keep = 1'b0;
            else m = (c == CH_SEMI) ? SM_NORMAL : SM_VALUE;
         end else begin
            if (c == CH_COMMA) m = SM_SKIP;
            else if (c == CH_SEMI) m = SM_NORMAL;
         end
         if (keep) r.st.space_mode = m;
      end

      if (keep && (s.error_code == ERR_OK)) begin
         unique case (s.parse_state)
            PS_NAME: begin
               if ((c == CH_LBRACE) || (c == CH_QUOTE)) begin
                  r.st.parse_state    = (c == CH_LBRACE) ? PS_PROP : PS_IDENT;
                  r.st.token_nonempty = 1'b0;
                  r.emit              = 1'b1;
                  r.cls               = CLS_DELIM;
               end else if (d) begin
                  r.st.error_code = ERR_SYNTAX;
               end else begin
                  r.st.token_nonempty = 1'b1;
                  r.emit              = 1'b1;
                  r.cls               = CLS_NAME;
               end
            end
            PS_IDENT: begin
               if (c == CH_QUOTE) begin
                  r.st.parse_state = PS_CLOSEQ;
                  r.emit           = 1'b1;
                  r.cls            = CLS_DELIM;
               end else if (d) begin
                  r.st.error_code = ERR_SYNTAX;
               end else begin
                  r.emit = 1'b1;
                  r.cls  = CLS_IDENT;
               end
            end
            PS_CLOSEQ: begin
               if (c == CH_LBRACE) begin
                  r.st.parse_state    = PS_PROP;
                  r.st.token_nonempty = 1'b0;
                  r.emit              = 1'b1;
                  r.cls               = CLS_DELIM;
               end else begin
                  r.st.error_code = ERR_SYNTAX;
               end
            end
            PS_PROP: begin
               if ((c == CH_RBRACE) && !s.token_nonempty) begin
                  r.st.parse_state = PS_NAME;
                  if (s.element_total != 16'hFFFF)
                     r.st.element_total = s.element_total + 16'd1;
                  r.emit = 1'b1;
                  r.cls  = CLS_DELIM;
               end else if (c == CH_COLON) begin
                  r.st.parse_state    = PS_VAL1;
                  r.st.token_nonempty = 1'b0;
                  r.emit              = 1'b1;
                  r.cls               = CLS_DELIM;
               end else if (d) begin
                  r.st.error_code = ERR_SYNTAX;
               end else begin
                  r.st.token_nonempty = 1'b1;
                  r.emit              = 1'b1;
                  r.cls               = CLS_PROP;
               end
            end
            PS_VAL1, PS_VALN: begin
               if ((c == CH_COMMA) || (c == CH_SEMI)) begin
                  // empty value, unless ';' closes a property with no values
                  if (!s.token_nonempty &&
                      !((c == CH_SEMI) && (s.parse_state == PS_VAL1))) begin
                     r.st.error_code = ERR_SYNTAX;
                  end else begin
                     r.st.parse_state    = (c == CH_COMMA) ? PS_VALN : PS_PROP;
                     r.st.token_nonempty = 1'b0;
                     r.emit              = 1'b1;
                     r.cls               = CLS_DELIM;
                  end
               end else if (d) begin
                  r.st.error_code = ERR_SYNTAX;
               end else begin
                  r.st.token_nonempty = 1'b1;
                  r.emit              = 1'b1;
                  r.cls               = CLS_VALUE;
               end
            end
            default: r.st.error_code = ERR_SYNTAX;
         endcase
      end
      return r;
   endfunction

endpackage

>>> rtl/btt_front.sv
`timescale 1ns / 1ps

module btt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_end_of_text,
   input  logic             q_full,
   output logic             push,
   output btt_pkg::rec_type push_rec
);
   import btt_pkg::*;

   logic     in_comment_ff, in_comment_in;
   logic     star_seen_ff, star_seen_in;
   logic     slash_pending_ff, slash_pending_in;
   ps_type   ps_ff, ps_in;

   logic     accept;
   logic     first_en, feed_c, second_en, sp_mid;
   logic     e0, e1;
   logic [7:0] ch2;
   ps_type   ps_a, ps_b, ps_c;
   feed_type fa, fb;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ps_a          = ps_ff;
      in_comment_in = in_comment_ff;
      star_seen_in  = star_seen_ff;
      sp_mid        = slash_pending_ff;
      first_en      = 1'b0;
      feed_c        = 1'b0;
      if (in_comment_ff) begin
         if (req_in_byte == CH_LF) ps_a.space_mode = SM_NORMAL;
         if (star_seen_ff && (req_in_byte == CH_SLASH)) begin
            in_comment_in = 1'b0;
            star_seen_in  = 1'b0;
         end else begin
            star_seen_in = (req_in_byte == CH_STAR);
         end
      end else if (slash_pending_ff && (req_in_byte == CH_STAR)) begin
         sp_mid        = 1'b0;
         in_comment_in = 1'b1;
         star_seen_in  = 1'b0;
      end else begin
         // held slash goes out ahead of this byte
         first_en = slash_pending_ff;
         sp_mid   = (req_in_byte == CH_SLASH);
         feed_c   = (req_in_byte != CH_SLASH);
      end

      fa   = feed_char(ps_a, CH_SLASH);
      ps_b = first_en ? fa.st : ps_a;

      // at most one of: this byte, or a slash released by end of text
      second_en        = feed_c || (req_end_of_text && sp_mid);
      ch2              = feed_c ? req_in_byte : CH_SLASH;
      slash_pending_in = sp_mid && !req_end_of_text;
      fb               = feed_char(ps_b, ch2);
      ps_c             = second_en ? fb.st : ps_b;

      if (req_end_of_text && (ps_c.error_code == ERR_OK) &&
          (in_comment_in || (ps_c.parse_state != PS_NAME) || ps_c.token_nonempty))
         ps_c.error_code = ERR_INCOMPLETE;
      ps_in = ps_c;

      e0 = first_en && fa.emit;
      e1 = second_en && fb.emit;

      push_rec.two    = e0 && e1;
      push_rec.has0   = e0 || e1;
      push_rec.ch0    = e0 ? CH_SLASH : (e1 ? ch2 : 8'd0);
      push_rec.cl0    = e0 ? fa.cls : (e1 ? fb.cls : CLS_NAME);
      push_rec.ch1    = ch2;
      push_rec.cl1    = fb.cls;
      push_rec.status = ps_c.error_code;
      push_rec.total  = ps_c.element_total;
      push_rec.eot    = req_end_of_text;

      push = accept && (e0 || e1 || req_end_of_text ||
                        (ps_c.error_code != ps_ff.error_code));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff    <= 1'b0;
         star_seen_ff     <= 1'b0;
         slash_pending_ff <= 1'b0;
         ps_ff            <= '0;
      end else if (accept) begin
         in_comment_ff    <= in_comment_in;
         star_seen_ff     <= star_seen_in;
         slash_pending_ff <= slash_pending_in;
         ps_ff            <= ps_in;
      end
   end

   a_star_in_comment: assert property (@(posedge clock) disable iff (reset)
      star_seen_ff |-> in_comment_ff)
      else $error("star flag set outside a comment");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (ps_ff.error_code != ERR_OK) |=> (ps_ff.error_code == $past(ps_ff.error_code)))
      else $error("error code changed after being set");

endmodule

>>> rtl/btt_queue.sv
`timescale 1ns / 1ps

module btt_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  btt_pkg::rec_type push_rec,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output btt_pkg::rec_type head
);
   import btt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("write into full queue");

endmodule

>>> rtl/btt_back.sv
`timescale 1ns / 1ps

module btt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  btt_pkg::rec_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_has_char,
   output logic [7:0]       rsp_out_char,
   output logic [2:0]       rsp_char_class,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_elements_done,
   output logic             rsp_final_res,
   output logic             rsp_last
);
   import btt_pkg::*;

   logic        rsp_valid_ff;
   logic        sub_ff;
   logic        has_ff, final_ff, last_ff;
   logic [7:0]  char_ff;
   logic [2:0]  class_ff;
   logic [1:0]  status_ff;
   logic [15:0] done_ff;
   logic        load, split;

   assign load  = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign split = head.two && !sub_ff;   // first of two words, head stays
   assign pop   = load && !split;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         sub_ff       <= split;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         has_ff    <= sub_ff ? 1'b1 : head.has0;
         char_ff   <= sub_ff ? head.ch1 : head.ch0;
         class_ff  <= sub_ff ? head.cl1 : head.cl0;
         status_ff <= head.status;
         done_ff   <= head.total;
         final_ff  <= head.eot;
         last_ff   <= !split;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_has_char      = has_ff;
   assign rsp_out_char      = char_ff;
   assign rsp_char_class    = class_ff;
   assign rsp_status        = status_ff;
   assign rsp_elements_done = done_ff;
   assign rsp_final_res     = final_ff;
   assign rsp_last          = last_ff;

   a_split_holds_head: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (!q_empty && head.two))
      else $error("second word pending without a two-word head");

endmodule

>>> rtl/block_text_tokenizer.sv
`timescale 1ns / 1ps
// An accepted byte's words go as one step into the step queue and are then registered onto rsp_.
// Throughput: one byte per cycle while the queue is not full; a byte giving two words holds the
// result port for both, and the step queue (QUEUE_DEPTH entries) between the classifier and the
// output absorbs that. A wordless byte (comment, blank) is queued only at end of text or error.
// Reset (synchronous, active high) clears all parser state, the queue and the output valid flag.

module block_text_tokenizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_char,
   output logic [7:0]  rsp_out_char,
   output logic [2:0]  rsp_char_class,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_elements_done,
   output logic        rsp_final_res,
   output logic        rsp_last
);
   import btt_pkg::*;

   logic    push, pop, q_full, q_empty;
   rec_type push_rec, head;

   btt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .q_full          (q_full),
      .push            (push),
      .push_rec        (push_rec)
   );

   btt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   btt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_has_char      (rsp_has_char),
      .rsp_out_char      (rsp_out_char),
      .rsp_char_class    (rsp_char_class),
      .rsp_status        (rsp_status),
      .rsp_elements_done (rsp_elements_done),
      .rsp_final_res     (rsp_final_res),
      .rsp_last          (rsp_last)
   );

endmodule
